// ===== hdl/two_set_store_algebra_defines.svh =====
// ----------------------------------------------------------------------------
// two_set_store_algebra_defines
// assertion macros used by the rtl top file
// ----------------------------------------------------------------------------
`ifndef TWO_SET_STORE_ALGEBRA_DEFINES_SVH
`define TWO_SET_STORE_ALGEBRA_DEFINES_SVH
`ifndef SYNTHESIS
`define TSSA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define TSSA_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TSSA_ASSERT(lbl, clk, rstn, prop, msg)
`define TSSA_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/tssa_pkg.sv =====
// ----------------------------------------------------------------------------
// tssa_pkg
// shared constants and types of the two-set store
// ----------------------------------------------------------------------------
`default_nettype none
package tssa_pkg;
  localparam int CAPACITY_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;
  localparam int CMD_W          = 3;
  localparam int CNT_W          = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 3'd0,
    CMD_CHECK = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_UNION = 3'd3,
    CMD_INTER = 3'd4,
    CMD_AMINB = 3'd5,
    CMD_SYMD  = 3'd6,
    CMD_CMP   = 3'd7
  } cmd_t;

  // result flags, one transaction
  typedef struct packed {
    logic             last;
    logic             result_empty;
    logic             found;
    logic             added;
    logic             full_res;
    logic             is_subset;
    logic             is_equal;
    logic [CNT_W-1:0] count_a;
    logic [CNT_W-1:0] count_b;
  } flags_t;
endpackage
`default_nettype wire

// ===== hdl/tssa_mem.sv =====
// ----------------------------------------------------------------------------
// tssa_mem
// one set store: single write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module tssa_mem #(
  parameter int DEPTH = tssa_pkg::CAPACITY_DEF,
  parameter int WIDTH = tssa_pkg::VALUE_BITS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/two_set_store_algebra.sv =====
// ----------------------------------------------------------------------------
// two_set_store_algebra
// two bounded integer sets in memories, with add, check, clear, compare and
// streamed union, intersection, difference and symmetric difference
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit up)              | tuser / tlast
// in_     | in  | command[2:0] value[34:3] (+5 pad)       | tuser set_select
// out_    | out | element[31:0]                           | tuser flags, tlast last
//
// add/check: one store read per cycle, result registered once the scan of the
//   selected set ends on a hit or at its count
// compare, intersect, a minus b: a scan of b for each element of a; union and
//   symmetric difference add a pass of b against a
// reset clears the counts and control state, not the stores; stored entries are read below the count only
// the scan stalls when a new element meets one not yet taken by the receiver;
//   a new command waits until the output register is empty
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_set_store_algebra_defines.svh"
module two_set_store_algebra #(
  parameter int CAPACITY   = tssa_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = tssa_pkg::VALUE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // command[2:0], value[34:3], zeros
  input  wire logic        in_tuser,   // set_select
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // element
  output logic             out_tlast,  // last
  output logic [23:0]      out_tuser   // result_empty, found, added, full_res,
                                       // is_subset, is_equal, count_a[5:0],
                                       // count_b[5:0], zeros
);
  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = tssa_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_OUTER, S_OWAIT, S_INNER, S_DONE, S_EMIT
  } state_t;

  // datapath registers
  state_t           state_r;
  tssa_pkg::cmd_t   cmd_r;
  logic             selb_r;
  logic [VALUE_BITS-1:0] val_r;     // value under test
  logic [CNT_W-1:0] cnt_a_r, cnt_b_r;
  logic [CNT_W-1:0] oi_r, ii_r;      // outer and inner indices
  logic             phase_r;         // 0: outer is A, 1: outer is B
  logic             hit_r, sub_r, any_r;
  logic             rd_pend_r;       // inner read in flight
  logic             ovalid_r;
  logic [31:0]      oelem_r;
  tssa_pkg::flags_t oflags_r;

  // memories
  logic            we_a, we_b;
  logic [AW-1:0]   ra_a, ra_b;
  logic [VALUE_BITS-1:0] rd_a, rd_b, wval;

  tssa_mem #(.DEPTH(CAPACITY), .WIDTH(VALUE_BITS)) u_mem_a (
    .clk(clk), .we(we_a), .waddr(cnt_a_r[AW-1:0]), .wdata(wval),
    .raddr(ra_a), .rdata(rd_a));
  tssa_mem #(.DEPTH(CAPACITY), .WIDTH(VALUE_BITS)) u_mem_b (
    .clk(clk), .we(we_b), .waddr(cnt_b_r[AW-1:0]), .wdata(wval),
    .raddr(ra_b), .rdata(rd_b));

  assign wval = val_r;

  // selections
  logic             is_simple;       // add or check: scan one set for val_r
  logic [CNT_W-1:0] in_cnt, out_cnt; // inner and outer set sizes
  logic [VALUE_BITS-1:0] in_data;
  logic             want;            // emit when membership equals this
  logic             skip_inner;      // union phase 0: A against empty
  logic             hit_now;

  always_comb begin
    is_simple = (cmd_r == tssa_pkg::CMD_ADD) || (cmd_r == tssa_pkg::CMD_CHECK);
    if (is_simple) begin
      in_cnt  = selb_r ? cnt_b_r : cnt_a_r;
      in_data = selb_r ? rd_b : rd_a;
    end else begin
      in_cnt  = phase_r ? cnt_a_r : cnt_b_r;
      in_data = phase_r ? rd_a : rd_b;
    end
    out_cnt    = phase_r ? cnt_b_r : cnt_a_r;
    want       = (cmd_r == tssa_pkg::CMD_INTER);
    skip_inner = (cmd_r == tssa_pkg::CMD_UNION) && !phase_r;
    hit_now    = rd_pend_r && (in_data == val_r);
  end

  // read addresses: inner scan index, or outer index in S_OUTER
  always_comb begin
    ra_a = ii_r[AW-1:0];
    ra_b = ii_r[AW-1:0];
    if (state_r == S_OUTER) begin
      ra_a = oi_r[AW-1:0];
      ra_b = oi_r[AW-1:0];
    end
  end

  logic can_out;
  assign can_out   = !ovalid_r || (out_tvalid && out_tready);
  assign in_tready = (state_r == S_IDLE) && !ovalid_r;

  // value narrowed to VALUE_BITS, sign-extended where wider
  logic [VALUE_BITS-1:0] in_val_n;
  assign in_val_n = VALUE_BITS'(signed'(in_tdata[34:3]));

  logic add_do;
  assign add_do = (cmd_r == tssa_pkg::CMD_ADD) && !hit_r
                  && (in_cnt < CNT_W'(CAPACITY));
  assign we_a = (state_r == S_DONE) && is_simple && add_do && !selb_r && can_out;
  assign we_b = (state_r == S_DONE) && is_simple && add_do && selb_r && can_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_a_r   <= '0;
      cnt_b_r   <= '0;
      ovalid_r  <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            cmd_r   <= tssa_pkg::cmd_t'(in_tdata[2:0]);
            selb_r  <= in_tuser;
            val_r   <= in_val_n;
            phase_r <= 1'b0;
            oi_r    <= '0;
            ii_r    <= '0;
            hit_r   <= 1'b0;
            sub_r   <= 1'b1;
            any_r   <= 1'b0;
            rd_pend_r <= 1'b0;
            case (tssa_pkg::cmd_t'(in_tdata[2:0]))
              tssa_pkg::CMD_ADD, tssa_pkg::CMD_CHECK: state_r <= S_INNER;
              tssa_pkg::CMD_CLEAR: state_r <= S_DONE;
              default: state_r <= S_OUTER;
            endcase
          end
        end
        S_OUTER: begin
          // fetch outer element oi_r
          if (oi_r >= out_cnt) begin
            if (cmd_r == tssa_pkg::CMD_CMP || cmd_r == tssa_pkg::CMD_INTER
                || cmd_r == tssa_pkg::CMD_AMINB || phase_r) begin
              state_r <= S_DONE;
            end else begin
              phase_r <= 1'b1;
              oi_r    <= '0;
            end
          end else begin
            state_r <= S_OWAIT;
          end
        end
        S_OWAIT: begin
          val_r     <= phase_r ? rd_b : rd_a;
          ii_r      <= '0;
          hit_r     <= 1'b0;
          rd_pend_r <= 1'b0;
          state_r   <= S_INNER;
        end
        S_INNER: begin
          // one read per cycle; compare the previous read
          rd_pend_r <= 1'b0;
          if (hit_now) hit_r <= 1'b1;
          if (hit_now || (!rd_pend_r && (skip_inner || ii_r >= in_cnt))
              || (rd_pend_r && ii_r >= in_cnt)) begin
            if (is_simple) state_r <= S_DONE;
            else state_r <= S_EMIT;
          end else if (!rd_pend_r || ii_r < in_cnt) begin
            if (ii_r < in_cnt) begin
              rd_pend_r <= 1'b1;
              ii_r      <= ii_r + 1'b1;
            end
          end
        end
        S_EMIT: begin
          // decide on outer element val_r
          if (cmd_r == tssa_pkg::CMD_CMP) begin
            if (!hit_r) sub_r <= 1'b0;
            oi_r    <= oi_r + 1'b1;
            state_r <= S_OUTER;
          end else if (hit_r == want) begin
            if (can_out) begin
              ovalid_r <= 1'b1;
              oelem_r  <= 32'(signed'(val_r));
              oflags_r <= '{last: 1'b0, result_empty: 1'b0, found: 1'b0,
                            added: 1'b0, full_res: 1'b0, is_subset: 1'b0,
                            is_equal: 1'b0, count_a: cnt_a_r, count_b: cnt_b_r};
              any_r    <= 1'b1;
              oi_r     <= oi_r + 1'b1;
              state_r  <= S_OUTER;
            end
          end else begin
            oi_r    <= oi_r + 1'b1;
            state_r <= S_OUTER;
          end
        end
        S_DONE: begin
          if (is_simple || cmd_r == tssa_pkg::CMD_CLEAR
              || cmd_r == tssa_pkg::CMD_CMP) begin
            if (can_out) begin
              logic [CNT_W-1:0] na, nb;
              na = cnt_a_r;
              nb = cnt_b_r;
              if (cmd_r == tssa_pkg::CMD_CLEAR) begin
                if (selb_r) nb = '0; else na = '0;
              end
              if (add_do && is_simple) begin
                if (selb_r) nb = cnt_b_r + 1'b1; else na = cnt_a_r + 1'b1;
              end
              cnt_a_r  <= na;
              cnt_b_r  <= nb;
              ovalid_r <= 1'b1;
              oelem_r  <= '0;
              oflags_r <= '{last: 1'b1, result_empty: 1'b0,
                            found: is_simple && hit_r,
                            added: is_simple && add_do,
                            full_res: (cmd_r == tssa_pkg::CMD_ADD) && !hit_r
                                      && !add_do,
                            is_subset: (cmd_r == tssa_pkg::CMD_CMP) && sub_r,
                            is_equal: (cmd_r == tssa_pkg::CMD_CMP) && sub_r
                                      && (cnt_a_r == cnt_b_r),
                            count_a: na, count_b: nb};
              state_r  <= S_IDLE;
            end
          end else if (!any_r) begin
            if (can_out) begin
              ovalid_r <= 1'b1;
              oelem_r  <= '0;
              oflags_r <= '{last: 1'b1, result_empty: 1'b1, found: 1'b0,
                            added: 1'b0, full_res: 1'b0, is_subset: 1'b0,
                            is_equal: 1'b0, count_a: cnt_a_r, count_b: cnt_b_r};
              state_r  <= S_IDLE;
            end
          end else begin
            // the held final element becomes last and may leave
            oflags_r.last <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a streamed element leaves only once the next element or the end is known
  // so hold it until decided: last flag is set in S_DONE while held
  assign out_tvalid = ovalid_r && !(oflags_r.last == 1'b0 && state_r != S_IDLE
                      && !(state_r == S_EMIT && hit_r == want
                           && cmd_r != tssa_pkg::CMD_CMP))
                      && !(oflags_r.last == 1'b0 && state_r == S_IDLE);
  assign out_tdata  = oelem_r;
  assign out_tlast  = oflags_r.last;
  assign out_tuser  = {6'b000000, oflags_r.count_b, oflags_r.count_a,
                       oflags_r.is_equal, oflags_r.is_subset, oflags_r.full_res,
                       oflags_r.added, oflags_r.found, oflags_r.result_empty};

  `TSSA_ASSERT(a_cnt_a_cap, clk, rst_n, cnt_a_r <= CNT_W'(CAPACITY), "count a over capacity")
  `TSSA_ASSERT(a_cnt_b_cap, clk, rst_n, cnt_b_r <= CNT_W'(CAPACITY), "count b over capacity")
  `TSSA_ASSERT(a_one_write, clk, rst_n, !(we_a && we_b), "both stores written")
  `TSSA_ASSERT(a_idle_take, clk, rst_n, in_tready |-> state_r == S_IDLE, "take while busy")
endmodule
`default_nettype wire

// ===== dv/tb_two_set_store_algebra.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_set_store_algebra
// self-checking bench for the two-set store: a directed opening, then a
// random mix of adds, lookups, clears, compares and streamed set operations,
// with random gaps on both channels and one long output stall
// ----------------------------------------------------------------------------

// one expected output transaction
typedef struct {
  logic [31:0] element;
  logic        last;
  logic        empty;
  logic        found;
  logic        added;
  logic        full;
  logic        subset;
  logic        equal;
  logic [5:0]  cnt_a;
  logic [5:0]  cnt_b;
} set_result_t;

class set_store_scoreboard;
  logic [31:0]  vals_a[32];
  logic [31:0]  vals_b[32];
  int           cnt_a;
  int           cnt_b;
  set_result_t  pending[$];
  int           errors;
  int           results_seen;

  function new();
    cnt_a = 0;
    cnt_b = 0;
    errors = 0;
    results_seen = 0;
  endfunction

  function bit is_member(bit in_b, logic [31:0] v, int lim);
    for (int i = 0; i < lim; i++) begin
      if ((in_b ? vals_b[i] : vals_a[i]) == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  function set_result_t blank_result();
    set_result_t r;
    r = '{default: '0};
    r.cnt_a = cnt_a[5:0];
    r.cnt_b = cnt_b[5:0];
    return r;
  endfunction

  // elements of one set that are (want) or are not in the other, in order
  function void stream_set(bit src_b, int other_lim, bit want);
    set_result_t r;
    int          n;
    logic [31:0] v;
    n = src_b ? cnt_b : cnt_a;
    for (int i = 0; i < n; i++) begin
      v = src_b ? vals_b[i] : vals_a[i];
      if (is_member(!src_b, v, other_lim) == want) begin
        r = blank_result();
        r.element = v;
        pending.push_back(r);
      end
    end
  endfunction

  // predicts the output transactions of one accepted input
  function void note_input(tssa_pkg::cmd_t c, bit sel_b, logic [31:0] v);
    set_result_t r;
    int          first;
    int          cur;
    bit          hit;
    if (c inside {tssa_pkg::CMD_ADD, tssa_pkg::CMD_CHECK, tssa_pkg::CMD_CLEAR,
                  tssa_pkg::CMD_CMP}) begin
      r = blank_result();
      cur = sel_b ? cnt_b : cnt_a;
      hit = 1'b0;
      if (c != tssa_pkg::CMD_CLEAR && c != tssa_pkg::CMD_CMP) begin
        hit = is_member(sel_b, v, cur);
      end
      r.found = hit;
      if (c == tssa_pkg::CMD_ADD && !hit) begin
        if (cur >= 32) begin
          r.full = 1'b1;
        end else begin
          if (sel_b) begin
            vals_b[cnt_b] = v;
            cnt_b++;
          end else begin
            vals_a[cnt_a] = v;
            cnt_a++;
          end
          r.added = 1'b1;
        end
      end
      if (c == tssa_pkg::CMD_CLEAR) begin
        if (sel_b) cnt_b = 0;
        else cnt_a = 0;
      end
      if (c == tssa_pkg::CMD_CMP) begin
        r.subset = 1'b1;
        for (int i = 0; i < cnt_a; i++) begin
          if (!is_member(1'b1, vals_a[i], cnt_b)) r.subset = 1'b0;
        end
        r.equal = r.subset && (cnt_a == cnt_b);
      end
      r.cnt_a = cnt_a[5:0];
      r.cnt_b = cnt_b[5:0];
      r.last = 1'b1;
      pending.push_back(r);
      return;
    end
    first = pending.size();
    case (c)
      tssa_pkg::CMD_UNION: begin
        stream_set(1'b0, 0, 1'b0);
        stream_set(1'b1, cnt_a, 1'b0);
      end
      tssa_pkg::CMD_INTER: stream_set(1'b0, cnt_b, 1'b1);
      tssa_pkg::CMD_AMINB: stream_set(1'b0, cnt_b, 1'b0);
      default: begin
        stream_set(1'b0, cnt_b, 1'b0);
        stream_set(1'b1, cnt_a, 1'b0);
      end
    endcase
    if (pending.size() == first) begin
      r = blank_result();
      r.last = 1'b1;
      r.empty = 1'b1;
      pending.push_back(r);
    end else begin
      pending[pending.size()-1].last = 1'b1;
    end
  endfunction

  function void report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s, expected %0h, actual %0h", $realtime, name,
               exp_v, act_v);
      errors++;
    end
  endfunction

  // compares one output transaction with the oldest expectation
  function void check_result(logic [31:0] data, logic lst, logic [23:0] user);
    set_result_t e;
    results_seen++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected output, expected none, actual element %0h", $realtime,
               data);
      errors++;
      return;
    end
    e = pending.pop_front();
    report_field("element", e.element, data);
    report_field("last", 32'(e.last), 32'(lst));
    report_field("result_empty", 32'(e.empty), 32'(user[0]));
    report_field("found", 32'(e.found), 32'(user[1]));
    report_field("added", 32'(e.added), 32'(user[2]));
    report_field("full_res", 32'(e.full), 32'(user[3]));
    report_field("is_subset", 32'(e.subset), 32'(user[4]));
    report_field("is_equal", 32'(e.equal), 32'(user[5]));
    report_field("count_a", 32'(e.cnt_a), 32'(user[11:6]));
    report_field("count_b", 32'(e.cnt_b), 32'(user[17:12]));
    report_field("pad", 32'd0, 32'(user[23:18]));
  endfunction
endclass

module tb_two_set_store_algebra;
  localparam int IDLE_LIMIT = 20000;   // cycles without any transaction
  localparam int HOLD_CYCLES = 400;    // long output stall

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic [23:0] out_tuser;

  set_store_scoreboard sb;
  bit  calm;         // no random gaps on either side
  bit  hold_req;     // asks the receiver for one long stall
  int  quiet_cycles;
  int  items_sent;
  int  op_counts[8];

  two_set_store_algebra u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // offers one command and waits for its transaction; a gap may go first
  task automatic send_cmd(tssa_pkg::cmd_t c, bit sel_b, logic [31:0] v);
    if (!calm && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, v, c};
    in_tuser  <= sel_b;
    do @(posedge clk); while (!in_tready);
    sb.note_input(c, sel_b, v);
    items_sent++;
    op_counts[c]++;
  endtask

  // small value pool so sets overlap, with an occasional full-range value
  function automatic logic [31:0] pick_value();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($signed($urandom_range(48)) - 24);
  endfunction

  // receiver: random back-pressure, one long stall on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_tready <= calm || ($urandom_range(99) >= 25);
    end
  end

  // output monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles > IDLE_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $realtime,
                 sb.pending.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    tssa_pkg::cmd_t c;
    int             roll;
    logic [31:0]    v;
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    items_sent = 0;
    op_counts = '{default: 0};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // both sets empty: compare and every set operation
    send_cmd(tssa_pkg::CMD_CMP, 1'b0, '0);
    send_cmd(tssa_pkg::CMD_UNION, 1'b1, '0);
    send_cmd(tssa_pkg::CMD_INTER, 1'b0, '0);
    send_cmd(tssa_pkg::CMD_AMINB, 1'b0, '0);
    send_cmd(tssa_pkg::CMD_SYMD, 1'b1, '0);
    // extremes of the value field, duplicate add, lookups in both sets
    send_cmd(tssa_pkg::CMD_ADD, 1'b0, 32'h8000_0000);
    send_cmd(tssa_pkg::CMD_ADD, 1'b0, 32'h7fff_ffff);
    send_cmd(tssa_pkg::CMD_ADD, 1'b0, 32'hffff_ffff);
    send_cmd(tssa_pkg::CMD_ADD, 1'b0, 32'h0);
    send_cmd(tssa_pkg::CMD_ADD, 1'b0, 32'hffff_ffff);
    send_cmd(tssa_pkg::CMD_CHECK, 1'b0, 32'h0);
    send_cmd(tssa_pkg::CMD_CHECK, 1'b1, 32'h0);
    // b empty: union gives a, the rest by definition
    send_cmd(tssa_pkg::CMD_UNION, 1'b0, '0);
    send_cmd(tssa_pkg::CMD_SYMD, 1'b0, '0);
    send_cmd(tssa_pkg::CMD_ADD, 1'b1, 32'h7fff_ffff);
    send_cmd(tssa_pkg::CMD_ADD, 1'b1, 32'd5);
    send_cmd(tssa_pkg::CMD_UNION, 1'b1, 32'hffff_ffff);
    send_cmd(tssa_pkg::CMD_INTER, 1'b0, '0);
    send_cmd(tssa_pkg::CMD_AMINB, 1'b0, '0);
    send_cmd(tssa_pkg::CMD_SYMD, 1'b0, '0);
    send_cmd(tssa_pkg::CMD_CMP, 1'b1, '0);
    // fill a to capacity, then a refused add
    for (int i = 0; i < 28; i++) send_cmd(tssa_pkg::CMD_ADD, 1'b0, 32'd100 + i);
    send_cmd(tssa_pkg::CMD_ADD, 1'b0, 32'd999);
    send_cmd(tssa_pkg::CMD_UNION, 1'b0, '0);
    send_cmd(tssa_pkg::CMD_CLEAR, 1'b0, '0);
    send_cmd(tssa_pkg::CMD_CLEAR, 1'b1, '0);

    // random part; one stretch without gaps and one long output stall
    for (int n = 0; n < 320; n++) begin
      calm = (n >= 120 && n < 170);
      if (n == 220) hold_req = 1'b1;
      roll = $urandom_range(99);
      if (roll < 42) c = tssa_pkg::CMD_ADD;
      else if (roll < 55) c = tssa_pkg::CMD_CHECK;
      else if (roll < 58) c = tssa_pkg::CMD_CLEAR;
      else c = tssa_pkg::cmd_t'($urandom_range(3, 7));
      v = pick_value();
      send_cmd(c, 1'($urandom_range(1)), v);
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime, sb.pending.size());
      sb.errors++;
    end

    $display("run covered %0d commands (%0d add, %0d check, %0d clear, %0d compare)",
             items_sent, op_counts[tssa_pkg::CMD_ADD], op_counts[tssa_pkg::CMD_CHECK],
             op_counts[tssa_pkg::CMD_CLEAR], op_counts[tssa_pkg::CMD_CMP]);
    $display("set operations %0d, output transactions checked %0d, mismatches %0d",
             op_counts[tssa_pkg::CMD_UNION] + op_counts[tssa_pkg::CMD_INTER]
             + op_counts[tssa_pkg::CMD_AMINB] + op_counts[tssa_pkg::CMD_SYMD],
             sb.results_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/tssa_pkg.sv
hdl/tssa_mem.sv
hdl/two_set_store_algebra.sv
dv/tb_two_set_store_algebra.sv
